/* src/double_ended_queue_top_assert.svh */
// Assertion macros for the double-ended queue checker.
// Needs clk and rst_n in the scope of each use.
`ifndef DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_TOP_ASSERT_SVH

// Check a condition in the same cycle as the trigger.
`define DEQ_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deque check failed");

// Check a condition in the cycle after the trigger.
`define DEQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deque check failed");

`endif

/* src/deq_pkg.sv */
// Shared request codes, word and result types for the double-ended queue.
// No dependencies.
package deq_pkg;

    typedef logic [2:0]         req_t;
    typedef logic signed [31:0] word_t;

    localparam req_t REQ_PUSH_FRONT = 3'd0;
    localparam req_t REQ_PUSH_BACK  = 3'd1;
    localparam req_t REQ_POP_FRONT  = 3'd2;
    localparam req_t REQ_POP_BACK   = 3'd3;
    localparam req_t REQ_SEARCH     = 3'd4;

    typedef struct packed {
        word_t      popped_value;
        logic       found;
        logic       empty_error;
        logic       full_error;
        word_t      front_word;
        word_t      back_word;
        logic [4:0] entry_count;
        logic       is_empty;
    } deq_result_t;

endpackage

/* src/deq_req_if.sv */
// Request channel of the double-ended queue: valid/ready plus request payload.
// Depends on deq_pkg.
interface deq_req_if;
    import deq_pkg::*;

    logic  valid;
    logic  ready;
    req_t  req_type;
    word_t value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink   (input valid, input req_type, input value, output ready);
endinterface

/* src/deq_res_if.sv */
// Result channel of the double-ended queue: valid/ready plus result payload.
// Depends on deq_pkg.
interface deq_res_if;
    import deq_pkg::*;

    logic       valid;
    logic       ready;
    word_t      popped_value;
    logic       found;
    logic       empty_error;
    logic       full_error;
    word_t      front_word;
    word_t      back_word;
    logic [4:0] entry_count;
    logic       is_empty;

    modport source (output valid, output popped_value, output found, output empty_error,
                    output full_error, output front_word, output back_word,
                    output entry_count, output is_empty, input ready);
    modport sink   (input valid, input popped_value, input found, input empty_error,
                    input full_error, input front_word, input back_word,
                    input entry_count, input is_empty, output ready);
endinterface

/* src/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/deq_core.sv */
// Sequencer of the double-ended queue: ring front pointer, count, and the
// shared RAM read port and comparator. Depends on deq_pkg and drives deq_ram.
module deq_core #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  deq_pkg::req_t            req_type,
    input  deq_pkg::word_t           req_value,
    output logic                     res_valid,
    input  logic                     res_ready,
    output deq_pkg::deq_result_t     res,
    output logic                     wr_en,
    output logic [$clog2(DEPTH)-1:0] wr_addr,
    output logic [31:0]              wr_data,
    output logic                     rd_en,
    output logic [$clog2(DEPTH)-1:0] rd_addr,
    input  logic [31:0]              rd_data
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam logic [SW-1:0] RING_SPAN = SW'(DEPTH);
    localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_EXEC    = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_FRONT   = 3'd3;
    localparam logic [2:0] S_BACK    = 3'd4;
    localparam logic [2:0] S_BACKCAP = 3'd5;
    localparam logic [2:0] S_DONE    = 3'd6;

    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offset);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offset);
        if (sum >= RING_SPAN)
        begin
            sum = sum - RING_SPAN;
        end
        return AW'(sum);
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          cmp_valid_reg, cmp_valid_next;
    logic          found_reg, found_next;
    logic          empty_err_reg, empty_err_next;
    logic          full_err_reg, full_err_next;
    logic          pop_ok_reg, pop_ok_next;
    req_t          op_reg, op_next;
    word_t         value_reg, value_next;
    word_t         popped_reg, popped_next;
    word_t         front_word_reg, front_word_next;
    word_t         back_word_reg, back_word_next;
    logic [AW-1:0] push_front_pos;
    logic          nonempty;
    logic          hit;

    assign nonempty       = (count_reg != '0);
    assign push_front_pos = (front_reg == '0) ? LAST_POS : front_reg - AW'(1);
    assign hit            = cmp_valid_reg && (rd_data == value_reg);

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        cmp_valid_next  = cmp_valid_reg;
        found_next      = found_reg;
        empty_err_next  = empty_err_reg;
        full_err_next   = full_err_reg;
        pop_ok_next     = pop_ok_reg;
        op_next         = op_reg;
        value_next      = value_reg;
        popped_next     = popped_reg;
        front_word_next = front_word_reg;
        back_word_next  = back_word_reg;
        wr_en           = 1'b0;
        wr_addr         = front_reg;
        wr_data         = value_reg;
        rd_en           = 1'b0;
        rd_addr         = front_reg;
        req_ready       = 1'b0;
        res_valid       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    op_next        = req_type;
                    value_next     = req_value;
                    found_next     = 1'b0;
                    empty_err_next = 1'b0;
                    full_err_next  = 1'b0;
                    pop_ok_next    = 1'b0;
                    popped_next    = '0;
                    state_next     = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FRONT;
                case (op_reg)
                    REQ_PUSH_FRONT:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            full_err_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = push_front_pos;
                            front_next = push_front_pos;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    REQ_PUSH_BACK:
                    begin
                        if (count_reg == FULL_CNT)
                        begin
                            full_err_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = ring_pos(front_reg, count_reg);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    REQ_POP_FRONT:
                    begin
                        if (!nonempty)
                        begin
                            empty_err_next = 1'b1;
                        end
                        else
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = front_reg;
                            pop_ok_next = 1'b1;
                            front_next  = ring_pos(front_reg, CW'(1));
                            count_next  = count_reg - CW'(1);
                        end
                    end
                    REQ_POP_BACK:
                    begin
                        if (!nonempty)
                        begin
                            empty_err_next = 1'b1;
                        end
                        else
                        begin
                            rd_en       = 1'b1;
                            rd_addr     = ring_pos(front_reg, count_reg - CW'(1));
                            pop_ok_next = 1'b1;
                            count_next  = count_reg - CW'(1);
                        end
                    end
                    REQ_SEARCH:
                    begin
                        if (!nonempty)
                        begin
                            empty_err_next = 1'b1;
                        end
                        else
                        begin
                            idx_next       = '0;
                            cmp_valid_next = 1'b0;
                            state_next     = S_SEARCH;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SEARCH:
            begin
                if (hit)
                begin
                    found_next     = 1'b1;
                    cmp_valid_next = 1'b0;
                    state_next     = S_FRONT;
                end
                else if (idx_reg == count_reg && !cmp_valid_reg)
                begin
                    state_next = S_FRONT;
                end
                else if (idx_reg != count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_addr        = ring_pos(front_reg, idx_reg);
                    idx_next       = idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
            end
            S_FRONT:
            begin
                if (pop_ok_reg)
                begin
                    popped_next = rd_data;
                end
                rd_en      = nonempty;
                rd_addr    = front_reg;
                state_next = S_BACK;
            end
            S_BACK:
            begin
                front_word_next = nonempty ? word_t'(rd_data) : '0;
                rd_en           = nonempty;
                rd_addr         = ring_pos(front_reg, count_reg - CW'(1));
                state_next      = S_BACKCAP;
            end
            S_BACKCAP:
            begin
                back_word_next = nonempty ? word_t'(rd_data) : '0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            empty_err_reg <= 1'b0;
            full_err_reg  <= 1'b0;
            pop_ok_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            found_reg     <= found_next;
            empty_err_reg <= empty_err_next;
            full_err_reg  <= full_err_next;
            pop_ok_reg    <= pop_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        value_reg      <= value_next;
        popped_reg     <= popped_next;
        front_word_reg <= front_word_next;
        back_word_reg  <= back_word_next;
    end

    always_comb
    begin
        res.popped_value = popped_reg;
        res.found        = found_reg;
        res.empty_error  = empty_err_reg;
        res.full_error   = full_err_reg;
        res.front_word   = front_word_reg;
        res.back_word    = back_word_reg;
        res.entry_count  = 5'(count_reg);
        res.is_empty     = !nonempty;
    end

endmodule

/* src/double_ended_queue_top.sv */
// Double-ended queue of signed 32-bit words in a ring of DEPTH RAM entries.
// Requests are push front, push back, pop front, pop back and search; every
// result also reports front word, back word, count and an empty flag. All
// RAM accesses share one read port and one write port under a sequencer.
// Pushes and pops step through the states execute, front read, back read,
// back capture and done; the result enters the output register in done.
// A search walks the stored entries through the single RAM read port:
// one entry is read and compared per cycle, front to back,
// and the walk stops at the first match. The request channel is ready only
// while the sequencer is idle; a finished result waits in the output
// register while the next request is taken.
module double_ended_queue_top #(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    deq_req_if.sink   req_ch,
    deq_res_if.source res_ch
);
    import deq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic          core_valid;
    logic          core_ready;
    deq_result_t   core_res;
    logic          out_valid_reg, out_valid_next;
    deq_result_t   out_data_reg;

    deq_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    deq_core #(
        .DEPTH (DEPTH)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .req_type  (req_ch.req_type),
        .req_value (req_ch.value),
        .res_valid (core_valid),
        .res_ready (core_ready),
        .res       (core_res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign core_ready = !out_valid_reg || res_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (core_valid && core_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_valid && core_ready)
        begin
            out_data_reg <= core_res;
        end
    end

    assign res_ch.valid        = out_valid_reg;
    assign res_ch.popped_value = out_data_reg.popped_value;
    assign res_ch.found        = out_data_reg.found;
    assign res_ch.empty_error  = out_data_reg.empty_error;
    assign res_ch.full_error   = out_data_reg.full_error;
    assign res_ch.front_word   = out_data_reg.front_word;
    assign res_ch.back_word    = out_data_reg.back_word;
    assign res_ch.entry_count  = out_data_reg.entry_count;
    assign res_ch.is_empty     = out_data_reg.is_empty;

endmodule

/* src/deq_checker.sv */
// Port-level checks for the double-ended queue, bound to the top level.
// Depends on deq_pkg and double_ended_queue_top_assert.svh.
`include "double_ended_queue_top_assert.svh"

module deq_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_ready,
    input logic           res_valid,
    input logic           res_ready,
    input deq_pkg::word_t popped_value,
    input logic           found,
    input logic           empty_error,
    input logic           full_error,
    input deq_pkg::word_t front_word,
    input deq_pkg::word_t back_word,
    input logic [4:0]     entry_count,
    input logic           is_empty
);
    import deq_pkg::*;

    // Hold a stalled result.
    `DEQ_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid)
    `DEQ_ASSERT_NEXT(a_res_stable, res_valid && !res_ready,
        $stable(popped_value) && $stable(front_word) && $stable(back_word) &&
        $stable(entry_count) && $stable(found) && $stable(empty_error))
    // Drop ready once a request transaction starts work.
    `DEQ_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
    `DEQ_ASSERT_NOW(a_empty_err_state, res_valid && empty_error,
        is_empty && !found && !full_error && popped_value == 0)
    `DEQ_ASSERT_NOW(a_empty_words, res_valid && is_empty,
        entry_count == 0 && front_word == 0 && back_word == 0)

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_ch.valid),
    .req_ready    (req_ch.ready),
    .res_valid    (res_ch.valid),
    .res_ready    (res_ch.ready),
    .popped_value (res_ch.popped_value),
    .found        (res_ch.found),
    .empty_error  (res_ch.empty_error),
    .full_error   (res_ch.full_error),
    .front_word   (res_ch.front_word),
    .back_word    (res_ch.back_word),
    .entry_count  (res_ch.entry_count),
    .is_empty     (res_ch.is_empty)
);
